// ----- rtl/core/retransmit_timer_tracker_defines.svh -----
// Assertion macros shared by the retransmit timer tracker RTL.
`ifndef RETRANSMIT_TIMER_TRACKER_DEFINES_SVH
`define RETRANSMIT_TIMER_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtt assertion failed");

// Next-cycle implication, checked outside reset.
`define RTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtt assertion failed");

`endif

// ----- rtl/core/rtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_pkg
// Types, constants and helpers of the retransmit timer tracker.
// ----------------------------------------------------------------------------
package rtt_pkg;

	localparam int WINDOW = 64;
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_ACK  = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [2:0] KIND_SENT     = 3'd0;
	localparam logic [2:0] KIND_REJECTED = 3'd1;
	localparam logic [2:0] KIND_ACKED    = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd3;
	localparam logic [2:0] KIND_RETX     = 3'd4;

	localparam logic [15:0] RTO_RESET = 16'd500;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] ack_seq;
		logic [31:0] now;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] seq;
		logic [15:0] retry_count;
		logic [31:0] last_acked;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] deadline;
		logic [15:0] retries;
	} slot_entry_t;

	// Lowest free slot; only used when at least one slot is free.
	function automatic logic [IDX_W-1:0] first_free(input logic [WINDOW-1:0] busy);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = WINDOW - 1; i >= 0; i--) begin
			if (!busy[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- rtl/core/retransmit_timer_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retransmit_timer_tracker
// Sender-side tracker of unacknowledged packets with retransmit timers.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data; each transfer moves one item. The field
// last marks the final result of an item. The user must write the timeout
// register through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this. A send writes its result from
// the SEND state. An ack walks the whole slot table through the one read
// port of the slot memory before its result is written. A tick makes one
// pass over the slot table per retransmitted packet, and a tick that
// expires nothing ends after its first pass without a result.
// Throughput is one item at a time; the next item is taken once the
// current one has handed its last result to the output register.
// Reset clears every slot, sets the sequence counter to zero, last_acked
// to all ones and the timeout to 500 ticks. When the receiver stalls, the
// output register holds its result and the block waits before writing the next.
// ----------------------------------------------------------------------------
module retransmit_timer_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rtt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rtt_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import rtt_pkg::*;
	`include "retransmit_timer_tracker_defines.svh"

	// One-hot control states.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SEND  = 6'b000010,
		ST_ASCAN = 6'b000100,
		ST_AFIN  = 6'b001000,
		ST_TSCAN = 6'b010000,
		ST_TEMIT = 6'b100000
	} state_t;

	state_t            state_q;
	logic [15:0]       rto_q;
	logic [WINDOW-1:0] busy_q;
	logic [WINDOW-1:0] due_q;
	logic [CNT_W-1:0]  busy_cnt_q;
	logic [31:0]       seq_ctr_q;
	logic [31:0]       acked_upto_q;
	in_item_t          item_q;

	// Scan pipeline: address counter, then one stage aligned with read data.
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;

	// Scan results.
	logic              found_q;
	logic              dup_q;
	logic [IDX_W-1:0]  pick_q;
	logic [31:0]       pick_seq_q;
	logic [31:0]       pick_age_q;
	logic [15:0]       pick_ret_q;
	logic [31:0]       dmin_q;
	logic              first_pass_q;
	logic [CNT_W-1:0]  due_cnt_q;
	logic [CNT_W-1:0]  emit_cnt_q;

	logic              out_valid_q;
	out_item_t         out_q;

	// Memory ports.
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	slot_entry_t       ram_wdata;
	logic              ram_re;
	slot_entry_t       ram_rdata;

	rtt_slot_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (scan_cnt_q[IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	logic              out_free;
	logic [15:0]       tmo;
	logic [31:0]       rearm;
	logic [31:0]       base;
	logic [IDX_W-1:0]  free_idx;
	logic              scanning;
	logic              scan_end;
	logic [31:0]       age;
	logic              expired;
	logic              cand;
	logic              better;
	logic              hit;
	logic [31:0]       seq_gap;
	logic [31:0]       ack_dist;
	logic [31:0]       adv;
	logic [31:0]       new_acked;
	logic [15:0]       ret_inc;
	logic              last_emit;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A timeout of zero behaves as one tick.
	assign tmo      = (rto_q == 16'd0) ? 16'd1 : rto_q;
	assign rearm    = item_q.now + {16'd0, tmo};
	assign base     = acked_upto_q + 32'd1;
	assign free_idx = first_free(busy_q);

	assign scanning = (state_q == ST_ASCAN) || (state_q == ST_TSCAN);
	assign ram_re   = scanning && (scan_cnt_q != CNT_W'(WINDOW));
	assign scan_end = vld_s1 && (idx_s1 == IDX_W'(WINDOW - 1));

	// Per-entry evaluation of the word coming out of the memory.
	assign age     = item_q.now - ram_rdata.deadline;
	assign expired = busy_q[idx_s1] && !age[31];
	assign cand    = first_pass_q ? expired : due_q[idx_s1];
	// Oldest deadline first; equal ages go to the lower sequence number.
	assign better  = !found_q || (age > pick_age_q) ||
		((age == pick_age_q) && (ram_rdata.seq < pick_seq_q));
	assign hit     = busy_q[idx_s1] && (ram_rdata.seq == item_q.ack_seq);
	assign seq_gap = ram_rdata.seq - base;

	// last_acked moves to one below the closest outstanding number. A second
	// slot holding the acked number stays outstanding and counts as well.
	assign ack_dist  = item_q.ack_seq - base;
	assign adv       = (dup_q && (ack_dist < dmin_q)) ? ack_dist : dmin_q;
	assign new_acked = acked_upto_q + adv;

	assign ret_inc   = (pick_ret_q == 16'hFFFF) ? pick_ret_q : pick_ret_q + 16'd1;
	assign last_emit = ((emit_cnt_q + CNT_W'(1)) == due_cnt_q);

	// Memory writes: a new slot on send, a rearmed slot on retransmit.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = free_idx;
		ram_wdata = '{seq: seq_ctr_q, deadline: rearm, retries: 16'd0};
		case (state_q)
			ST_SEND: begin
				ram_we = out_free && (busy_cnt_q != CNT_W'(WINDOW));
			end
			ST_TEMIT: begin
				ram_we    = out_free;
				ram_waddr = pick_q;
				ram_wdata = '{seq: pick_seq_q, deadline: rearm, retries: ret_inc};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rto_q        <= RTO_RESET;
			busy_q       <= '0;
			due_q        <= '0;
			busy_cnt_q   <= '0;
			seq_ctr_q    <= '0;
			acked_upto_q <= '1;
			scan_cnt_q   <= '0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			dup_q        <= 1'b0;
			first_pass_q <= 1'b0;
			due_cnt_q    <= '0;
			emit_cnt_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				rto_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= ram_re;
			if (ram_re) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end

			case (state_q)
				ST_IDLE: begin
					scan_cnt_q   <= '0;
					found_q      <= 1'b0;
					dup_q        <= 1'b0;
					first_pass_q <= 1'b1;
					due_cnt_q    <= '0;
					emit_cnt_q   <= '0;
					dmin_q       <= seq_ctr_q - base;
					if (in_valid) begin
						case (in_data.action)
							ACT_SEND: state_q <= ST_SEND;
							ACT_ACK:  state_q <= ST_ASCAN;
							ACT_TICK: state_q <= ST_TSCAN;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end

				ST_SEND: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.seq         <= seq_ctr_q;
						out_q.retry_count <= 16'd0;
						out_q.last_acked  <= acked_upto_q;
						out_q.last        <= 1'b1;
						if (busy_cnt_q == CNT_W'(WINDOW)) begin
							out_q.kind <= KIND_REJECTED;
						end else begin
							out_q.kind       <= KIND_SENT;
							busy_q[free_idx] <= 1'b1;
							busy_cnt_q       <= busy_cnt_q + CNT_W'(1);
							seq_ctr_q        <= seq_ctr_q + 32'd1;
						end
						state_q <= ST_IDLE;
					end
				end

				ST_ASCAN: begin
					if (vld_s1) begin
						if (hit && !found_q) begin
							found_q    <= 1'b1;
							pick_q     <= idx_s1;
							pick_ret_q <= ram_rdata.retries;
						end else if (hit) begin
							dup_q <= 1'b1;
						end
						if (busy_q[idx_s1] && !hit && (seq_gap < dmin_q)) begin
							dmin_q <= seq_gap;
						end
					end
					if (scan_end) begin
						state_q <= ST_AFIN;
					end
				end

				ST_AFIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.seq   <= item_q.ack_seq;
						out_q.last  <= 1'b1;
						if (found_q) begin
							out_q.kind        <= KIND_ACKED;
							out_q.retry_count <= pick_ret_q;
							out_q.last_acked  <= new_acked;
							acked_upto_q      <= new_acked;
							busy_q[pick_q]    <= 1'b0;
							busy_cnt_q        <= busy_cnt_q - CNT_W'(1);
						end else begin
							out_q.kind        <= KIND_UNKNOWN;
							out_q.retry_count <= 16'd0;
							out_q.last_acked  <= acked_upto_q;
						end
						state_q <= ST_IDLE;
					end
				end

				ST_TSCAN: begin
					if (vld_s1) begin
						if (first_pass_q) begin
							due_q[idx_s1] <= expired;
							if (expired) begin
								due_cnt_q <= due_cnt_q + CNT_W'(1);
							end
						end
						if (cand && better) begin
							found_q    <= 1'b1;
							pick_q     <= idx_s1;
							pick_seq_q <= ram_rdata.seq;
							pick_age_q <= age;
							pick_ret_q <= ram_rdata.retries;
						end
					end
					if (scan_end) begin
						// A first pass with nothing due ends the tick silently.
						state_q <= (found_q || (cand && better)) ? ST_TEMIT : ST_IDLE;
					end
				end

				ST_TEMIT: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.kind        <= KIND_RETX;
						out_q.seq         <= pick_seq_q;
						out_q.retry_count <= ret_inc;
						out_q.last_acked  <= acked_upto_q;
						out_q.last        <= last_emit;
						due_q[pick_q]     <= 1'b0;
						emit_cnt_q        <= emit_cnt_q + CNT_W'(1);
						found_q           <= 1'b0;
						first_pass_q      <= 1'b0;
						scan_cnt_q        <= '0;
						state_q           <= last_emit ? ST_IDLE : ST_TSCAN;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		idx_s1 <= scan_cnt_q[IDX_W-1:0];
	end

	`RTT_ASSERT_NOW(a_busy_count, 1'b1, busy_cnt_q == CNT_W'($countones(busy_q)))
	`RTT_ASSERT_NOW(a_no_write_in_scan, ram_we, !scanning)
	`RTT_ASSERT_NEXT(a_acked_only_on_ack, state_q != ST_AFIN, $stable(acked_upto_q))
	`RTT_ASSERT_NOW(a_emit_bound, state_q == ST_TEMIT, emit_cnt_q < due_cnt_q)

endmodule

// ----- rtl/core/rtt_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_slot_ram
// Slot table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtt_slot_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [rtt_pkg::IDX_W-1:0]   wr_addr,
	input  rtt_pkg::slot_entry_t        wr_data,
	input  logic                        rd_en,
	input  logic [rtt_pkg::IDX_W-1:0]   rd_addr,
	output rtt_pkg::slot_entry_t        rd_data
);
	import rtt_pkg::*;

	slot_entry_t mem [WINDOW];
	slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
